>>> sv/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define NEC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("nec_ir: assertion failed");

// Check that a condition is followed by another in the next cycle.
`define NEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nec_ir: assertion failed");

`endif

>>> sv/nec_ir_pkg.sv
// Package for the NEC infrared pulse decoder: types, register indexes,
// reset values and event codes. No dependencies.
`timescale 1ns / 1ps

package nec_ir_pkg;

  // Fixed field widths
  localparam int STAMP_W   = 16;
  localparam int TARGET_W  = 14;
  localparam int PCT_W     = 7;
  localparam int WORD_BITS = 32;
  localparam int BOUND_W   = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;

  // Default parameter values
  localparam int DEF_FRAME_BITS       = 32;
  localparam int DEF_FRAME_TIMEOUT_US = 14000;
  localparam int DEF_TIMER_BITS       = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_RELOAD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HDR_MARK     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HDR_SPACE    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RPT_SPACE    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TOL_PCT      = 4'd7;

  // Register reset values
  localparam logic [STAMP_W-1:0]  RST_TIMER_RELOAD = 16'd65535;
  localparam logic [TARGET_W-1:0] RST_HDR_MARK     = 14'd9000;
  localparam logic [TARGET_W-1:0] RST_HDR_SPACE    = 14'd4500;
  localparam logic [TARGET_W-1:0] RST_RPT_SPACE    = 14'd2250;
  localparam logic [TARGET_W-1:0] RST_BIT_MARK     = 14'd560;
  localparam logic [TARGET_W-1:0] RST_ZERO_SPACE   = 14'd560;
  localparam logic [TARGET_W-1:0] RST_ONE_SPACE    = 14'd1690;
  localparam logic [PCT_W-1:0]    RST_TOL_PCT      = 7'd28;

  // Event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_FRAME  = 2'd1;
  localparam logic [1:0] EV_REPEAT = 2'd2;

  // Cycles from a target or percent change to a settled window
  localparam int TOL_LAT = 3;

  // Acceptance window for one target
  typedef struct packed {
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
  } win_t;

  // All windows used by the decoder
  typedef struct packed {
    win_t hdr_mark;
    win_t hdr_space;
    win_t rpt_space;
    win_t bit_mark;
    win_t zero_space;
    win_t one_space;
  } win_set_t;

  // One result item
  typedef struct packed {
    logic [1:0]           event_res;
    logic [WORD_BITS-1:0] frame_word;
    logic                 receiving;
  } res_t;

endpackage

>>> sv/nec_ir_ifs.sv
// Channel interfaces of the NEC infrared pulse decoder: edge input,
// result output and configuration write. Depends on nec_ir_pkg.
`timescale 1ns / 1ps

interface nec_ir_in_if import nec_ir_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [STAMP_W-1:0] timestamp_us;
  logic               pin_level;
  modport source (output valid, op, timestamp_us, pin_level, input ready);
  modport sink   (input valid, op, timestamp_us, pin_level, output ready);
endinterface

interface nec_ir_out_if import nec_ir_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           event_res;
  logic [WORD_BITS-1:0] frame_word;
  logic                 receiving;
  modport source (output valid, event_res, frame_word, receiving, input ready);
  modport sink   (input valid, event_res, frame_word, receiving, output ready);
endinterface

interface nec_ir_cfg_if import nec_ir_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/nec_ir_tol.sv
// Tolerance window for one timing target: lo/hi = target -/+ target*pct/100.
// Three register stages; depends on nec_ir_pkg.
`timescale 1ns / 1ps

module nec_ir_tol import nec_ir_pkg::*; (
  input  logic                clk,
  input  logic [TARGET_W-1:0] target,
  input  logic [PCT_W-1:0]    pct,
  output win_t                win
);

  localparam int PROD_W = TARGET_W + PCT_W;   // 21 bits
  localparam int Y_W    = PROD_W - 2;         // product / 4
  localparam int RCP_W  = 15;
  localparam int MUL_W  = Y_W + RCP_W;
  localparam int TOL_W  = 15;
  localparam int RCP_SH = 19;
  localparam logic [RCP_W-1:0]  RCP_25  = 15'd20971;  // floor(2^19 / 25)
  localparam logic [PROD_W-1:0] HUNDRED = 21'd100;

  logic [PROD_W-1:0] prod_r, prod2_r;
  logic [TOL_W-1:0]  q0_r, tol_r;
  logic [MUL_W-1:0]  mul_c;
  logic [PROD_W-1:0] q0_x100, rem_c;
  logic [TOL_W-1:0]  tol_nxt;
  logic [BOUND_W-1:0] tgt_x, tol_x;

  // Estimate the quotient, at most one below the true value
  assign mul_c = MUL_W'(prod_r[PROD_W-1:2]) * MUL_W'(RCP_25);

  // Correct the estimate with one compare
  assign q0_x100 = (PROD_W'(q0_r) << 6) + (PROD_W'(q0_r) << 5) + (PROD_W'(q0_r) << 2);
  assign rem_c   = prod2_r - q0_x100;
  assign tol_nxt = q0_r + TOL_W'(rem_c >= HUNDRED);

  always_ff @(posedge clk) begin
    prod_r  <= PROD_W'(target) * PROD_W'(pct);
    prod2_r <= prod_r;
    q0_r    <= TOL_W'(mul_c >> RCP_SH);
    tol_r   <= tol_nxt;
  end

  // Build the window; hold the lower bound at zero for wide tolerances
  assign tgt_x  = BOUND_W'(target);
  assign tol_x  = BOUND_W'(tol_r);
  assign win.lo = (tol_x > tgt_x) ? '0 : tgt_x - tol_x;
  assign win.hi = tgt_x + tol_x;

endmodule

>>> sv/nec_ir_core.sv
// Decode step and result register: pulse length, window match, bit shift
// and frame/repeat reporting. Depends on nec_ir_pkg.
`timescale 1ns / 1ps

module nec_ir_core import nec_ir_pkg::*; #(
  parameter int FRAME_BITS       = DEF_FRAME_BITS,
  parameter int FRAME_TIMEOUT_US = DEF_FRAME_TIMEOUT_US,
  parameter int TIMER_BITS       = DEF_TIMER_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_v,
  input  logic               op,
  input  logic [STAMP_W-1:0] stamp,
  input  logic               level,
  input  logic [STAMP_W-1:0] reload,
  input  win_set_t           wins,
  input  logic               res_ready,
  output logic               slot_free,
  output logic               res_v,
  output res_t               res
);

  localparam int LW  = TIMER_BITS + 1;
  localparam int CW  = (LW > 17) ? LW : 17;
  localparam int BCW = $clog2(FRAME_BITS + 1);
  localparam logic [STAMP_W-1:0] STAMP_MASK = (TIMER_BITS >= STAMP_W) ? '1 :
    STAMP_W'((64'd1 << TIMER_BITS) - 64'd1);
  localparam logic [BCW:0]  FB_C    = (BCW + 1)'(FRAME_BITS);
  localparam logic [CW-1:0] TIMEOUT = CW'(FRAME_TIMEOUT_US);

  typedef enum logic [1:0] {
    PH_IDLE, PH_HDR_SPACE, PH_BIT_MARK, PH_BIT_SPACE
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [WORD_BITS-1:0] shift_r, shift_nxt;
  logic [BCW-1:0]       bcnt_r, bcnt_nxt;
  logic [STAMP_W-1:0]   last_t_r, last_t_nxt;
  logic                 last_l_r, last_l_nxt;
  logic                 res_v_r;
  res_t                 res_r, res_nxt;

  logic [STAMP_W-1:0] now_c;
  logic [LW-1:0]      wrap_c;
  logic [CW-1:0]      len_c;
  logic [BCW:0]       bnum_c;
  logic [WORD_BITS-1:0] word_c;
  logic               fire;

  function automatic logic near(input logic [CW-1:0] len, input win_t w);
    near = (len >= CW'(w.lo)) && (len <= CW'(w.hi));
  endfunction

  assign slot_free = !res_v_r || res_ready;
  assign fire      = item_v && slot_free;

  // Length of the level that just ended, with counter wrap
  assign now_c  = stamp & STAMP_MASK;
  assign wrap_c = LW'(reload) - LW'(last_t_r) + LW'(now_c) + LW'(1);
  assign len_c  = (now_c >= last_t_r) ? CW'(now_c - last_t_r) : CW'(wrap_c);

  assign bnum_c = {1'b0, bcnt_r} + 1'b1;
  assign word_c = shift_r | (WORD_BITS'(1) << bcnt_r);

  // Next decoder state and result
  always_comb begin
    phase_nxt  = phase_r;
    shift_nxt  = shift_r;
    bcnt_nxt   = bcnt_r;
    last_t_nxt = last_t_r;
    last_l_nxt = last_l_r;
    res_nxt.event_res  = EV_NONE;
    res_nxt.frame_word = '0;
    if (op) begin
      if (phase_r != PH_IDLE && len_c > TIMEOUT) begin
        phase_nxt = PH_IDLE;
        shift_nxt = '0;
        bcnt_nxt  = '0;
      end
    end else begin
      last_t_nxt = now_c;
      last_l_nxt = level;
      case (phase_r)
        PH_IDLE: begin
          if (!last_l_r && near(len_c, wins.hdr_mark)) phase_nxt = PH_HDR_SPACE;
        end
        PH_HDR_SPACE: begin
          phase_nxt = PH_IDLE;
          shift_nxt = '0;
          bcnt_nxt  = '0;
          if (last_l_r && near(len_c, wins.hdr_space)) begin
            phase_nxt = PH_BIT_MARK;
          end else if (last_l_r && near(len_c, wins.rpt_space)) begin
            res_nxt.event_res = EV_REPEAT;
          end
        end
        PH_BIT_MARK: begin
          if (!last_l_r && near(len_c, wins.bit_mark)) begin
            phase_nxt = PH_BIT_SPACE;
          end else begin
            phase_nxt = PH_IDLE;
            shift_nxt = '0;
            bcnt_nxt  = '0;
          end
        end
        PH_BIT_SPACE: begin
          if (last_l_r && (near(len_c, wins.zero_space) ||
                           near(len_c, wins.one_space))) begin
            // A zero wins when both windows overlap
            if (!near(len_c, wins.zero_space)) shift_nxt = word_c;
            phase_nxt = PH_BIT_MARK;
            bcnt_nxt  = BCW'(bnum_c);
            if (bnum_c >= FB_C) begin
              if (shift_nxt[23:16] == ~shift_nxt[31:24]) begin
                res_nxt.event_res  = EV_FRAME;
                res_nxt.frame_word = shift_nxt;
              end
              phase_nxt = PH_IDLE;
              shift_nxt = '0;
              bcnt_nxt  = '0;
            end
          end else begin
            phase_nxt = PH_IDLE;
            shift_nxt = '0;
            bcnt_nxt  = '0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          shift_nxt = '0;
          bcnt_nxt  = '0;
        end
      endcase
    end
    res_nxt.receiving = (phase_nxt != PH_IDLE);
  end

  // Hold state and result; advance only when an item fires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      shift_r  <= '0;
      bcnt_r   <= '0;
      last_t_r <= '0;
      last_l_r <= 1'b1;
      res_v_r  <= 1'b0;
    end else begin
      if (fire) begin
        phase_r  <= phase_nxt;
        shift_r  <= shift_nxt;
        bcnt_r   <= bcnt_nxt;
        last_t_r <= last_t_nxt;
        last_l_r <= last_l_nxt;
        res_v_r  <= 1'b1;
      end else if (res_ready) begin
        res_v_r  <= 1'b0;
      end
    end
    if (fire) res_r <= res_nxt;
  end

  assign res_v = res_v_r;
  assign res   = res_r;

endmodule

>>> sv/nec_ir_pulse_decoder_unit.sv
// Top level of the NEC infrared pulse decoder: configuration registers,
// tolerance units, input register and decode core. Depends on nec_ir_pkg,
// the channel interfaces, nec_ir_tol, nec_ir_core and assert_macros.svh.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    op, timestamp_us, pin_level
//   out_ch   out  valid/ready    event_res, frame_word, receiving
//   cfg_ch   in   valid/ready    index, data (ready always high)
//
// One result item per input item, one item per cycle sustained while out_ch accepts;
// items pass the input register, then the result register. Reset and any
// register write hold in_ch.ready low while the tolerance multiply and
// divide-by-100 pipeline settles. A stalled out_ch holds one item in the
// input register before in_ch.ready drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nec_ir_pulse_decoder_unit import nec_ir_pkg::*; #(
  parameter int FRAME_BITS       = DEF_FRAME_BITS,
  parameter int FRAME_TIMEOUT_US = DEF_FRAME_TIMEOUT_US,
  parameter int TIMER_BITS       = DEF_TIMER_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  nec_ir_in_if.sink    in_ch,
  nec_ir_out_if.source out_ch,
  nec_ir_cfg_if.sink   cfg_ch
);

  localparam int SCW = $clog2(TOL_LAT + 1);
  localparam logic [SCW-1:0] SETTLE = SCW'(TOL_LAT);

  logic [STAMP_W-1:0]  reload_r;
  logic [TARGET_W-1:0] hdr_mark_r, hdr_space_r, rpt_space_r;
  logic [TARGET_W-1:0] bit_mark_r, zero_space_r, one_space_r;
  logic [PCT_W-1:0]    pct_r;
  logic [SCW-1:0]      settle_r;
  logic                cfg_we;

  logic               in_v_r;
  logic               op_r, lvl_r;
  logic [STAMP_W-1:0] ts_r;
  logic               in_acc, slot_free, res_v;
  win_set_t           wins;
  res_t               res;

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  // Write configuration registers; restart the settle count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r     <= RST_TIMER_RELOAD;
      hdr_mark_r   <= RST_HDR_MARK;
      hdr_space_r  <= RST_HDR_SPACE;
      rpt_space_r  <= RST_RPT_SPACE;
      bit_mark_r   <= RST_BIT_MARK;
      zero_space_r <= RST_ZERO_SPACE;
      one_space_r  <= RST_ONE_SPACE;
      pct_r        <= RST_TOL_PCT;
      settle_r     <= SETTLE;
    end else begin
      if (cfg_we) begin
        settle_r <= SETTLE;
        case (cfg_ch.index)
          REG_TIMER_RELOAD: reload_r     <= cfg_ch.data;
          REG_HDR_MARK:     hdr_mark_r   <= cfg_ch.data[TARGET_W-1:0];
          REG_HDR_SPACE:    hdr_space_r  <= cfg_ch.data[TARGET_W-1:0];
          REG_RPT_SPACE:    rpt_space_r  <= cfg_ch.data[TARGET_W-1:0];
          REG_BIT_MARK:     bit_mark_r   <= cfg_ch.data[TARGET_W-1:0];
          REG_ZERO_SPACE:   zero_space_r <= cfg_ch.data[TARGET_W-1:0];
          REG_ONE_SPACE:    one_space_r  <= cfg_ch.data[TARGET_W-1:0];
          REG_TOL_PCT:      pct_r        <= cfg_ch.data[PCT_W-1:0];
          default: ;
        endcase
      end else if (settle_r != '0) begin
        settle_r <= settle_r - 1'b1;
      end
    end
  end

  // Tolerance windows, one unit per target
  nec_ir_tol u_tol_hm (.clk, .target(hdr_mark_r),   .pct(pct_r), .win(wins.hdr_mark));
  nec_ir_tol u_tol_hs (.clk, .target(hdr_space_r),  .pct(pct_r), .win(wins.hdr_space));
  nec_ir_tol u_tol_rs (.clk, .target(rpt_space_r),  .pct(pct_r), .win(wins.rpt_space));
  nec_ir_tol u_tol_bm (.clk, .target(bit_mark_r),   .pct(pct_r), .win(wins.bit_mark));
  nec_ir_tol u_tol_zs (.clk, .target(zero_space_r), .pct(pct_r), .win(wins.zero_space));
  nec_ir_tol u_tol_os (.clk, .target(one_space_r),  .pct(pct_r), .win(wins.one_space));

  // Input register: take an item when settled and empty or draining this cycle
  assign in_ch.ready = (settle_r == '0) && (!in_v_r || slot_free);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_acc) begin
      in_v_r <= 1'b1;
    end else if (slot_free) begin
      in_v_r <= 1'b0;
    end
    if (in_acc) begin
      op_r  <= in_ch.op;
      ts_r  <= in_ch.timestamp_us;
      lvl_r <= in_ch.pin_level;
    end
  end

  nec_ir_core #(
    .FRAME_BITS      (FRAME_BITS),
    .FRAME_TIMEOUT_US(FRAME_TIMEOUT_US),
    .TIMER_BITS      (TIMER_BITS)
  ) u_core (
    .clk,
    .rst_n,
    .item_v   (in_v_r),
    .op       (op_r),
    .stamp    (ts_r),
    .level    (lvl_r),
    .reload   (reload_r),
    .wins     (wins),
    .res_ready(out_ch.ready),
    .slot_free(slot_free),
    .res_v    (res_v),
    .res      (res)
  );

  assign out_ch.valid      = res_v;
  assign out_ch.event_res  = res.event_res;
  assign out_ch.frame_word = res.frame_word;
  assign out_ch.receiving  = res.receiving;

  // A report always leaves the decoder idle
  `NEC_ASSERT(a_report_idle, clk, rst_n,
    !(out_ch.valid && out_ch.event_res != EV_NONE && out_ch.receiving))
  // A reported frame passed the command check
  `NEC_ASSERT(a_frame_check, clk, rst_n,
    !(out_ch.valid && out_ch.event_res == EV_FRAME) ||
    (out_ch.frame_word[23:16] == ~out_ch.frame_word[31:24]))
  // Only frame reports carry a word
  `NEC_ASSERT(a_word_zero, clk, rst_n,
    !(out_ch.valid && out_ch.event_res != EV_FRAME) || (out_ch.frame_word == '0))
  // A register write blocks input while the windows settle
  `NEC_ASSERT_NEXT(a_cfg_stall, clk, rst_n, cfg_ch.valid && cfg_ch.ready, !in_ch.ready)

endmodule
